FILE: rtl/core/ntc_pkg.sv
// Package for the NTC trimmed-mean temperature unit.
// Holds shared types, constants and the temperature table builder.
// No dependencies.
`default_nettype none

package ntc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TEMP_W     = 11;
  localparam int GSUM_W     = 13;
  localparam int GROUP_LEN  = 5;
  localparam int ROM_DEPTH  = 1024;
  // Reciprocal of the group length in Q15; exact for every 13-bit group sum.
  localparam int RECIP5_Q15 = 6554;
  localparam int RECIP5_SH  = 15;

  localparam logic [SAMPLE_W-1:0] CELL_EMPTY = '1;

  localparam longint unsigned C_298LN2_Q28 = 64'd55447453288;
  localparam longint unsigned BETA_T0      = 64'd1189020;
  localparam longint unsigned ZERO_C_Q16   = 64'd273 << 16;
  localparam longint unsigned BETA_Q24     = 64'd3990 << 24;
  localparam int unsigned     MAX_Q4       = 1760;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] value;
  } sort_pass_t;

  typedef logic [TEMP_W-1:0] temp_rom_t [ROM_DEPTH];

  // Base-2 logarithm in Q32 by normalizing and repeated squaring.
  function automatic longint unsigned log2_q32(input int unsigned n_in);
    int unsigned     n;
    int unsigned     k;
    longint unsigned m;
    longint unsigned frac;
    n    = (n_in == 0) ? 1 : n_in;
    k    = 0;
    frac = 0;
    for (int b = 0; b < 31; b++) begin
      if ((n >> (b + 1)) != 0) k = b + 1;
    end
    m = longint'(n) << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(k) << 32) | frac;
  endfunction

  // Restoring long division, one quotient bit per step.
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned dvs);
    longint unsigned rem;
    longint unsigned quo;
    rem = 0;
    quo = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      quo = quo << 1;
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Temperature in 1/16 C for one filtered value, clamped to 0..110 C.
  function automatic logic [TEMP_W-1:0] to_temperature(input int unsigned v_in);
    int unsigned     v;
    longint unsigned la;
    longint unsigned lb;
    longint unsigned mag;
    longint unsigned p;
    longint unsigned den;
    longint unsigned kq16;
    longint unsigned q;
    logic            neg;
    v   = (v_in == 0) ? 1 : v_in;
    la  = log2_q32(9 * (1024 - v));
    lb  = log2_q32(25 * v);
    neg = la < lb;
    mag = (neg ? (lb - la) : (la - lb)) >> 8;
    p   = (mag * C_298LN2_Q28) >> 28;
    den = BETA_Q24;
    if (neg) begin
      if (p >= den) return TEMP_W'(MAX_Q4);
      den = den - p;
    end else begin
      den = den + p;
    end
    kq16 = long_div(BETA_T0 << 40, den);
    if (kq16 < ZERO_C_Q16) return '0;
    q = (kq16 - ZERO_C_Q16 + 64'd2048) >> 12;
    if (q > longint'(MAX_Q4)) q = longint'(MAX_Q4);
    return q[TEMP_W-1:0];
  endfunction

  function automatic temp_rom_t build_temp_rom();
    temp_rom_t t;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      t[i] = to_temperature(i);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ntc_if.sv
// Valid/ready channel interfaces for samples and results.
// Depends on ntc_pkg.
`default_nettype none

interface ntc_in_if import ntc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  modport source (output valid, adc_sample, input ready);
  modport sink   (input valid, adc_sample, output ready);
endinterface

interface ntc_out_if import ntc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered_adc;
  logic [TEMP_W-1:0]   temperature_q4;
  modport source (output valid, filtered_adc, temperature_q4, input ready);
  modport sink   (input valid, filtered_adc, temperature_q4, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ntc_trimmed_mean_temperature_unit.sv
// Top level of the NTC trimmed-mean temperature unit.
// Depends on ntc_pkg, ntc_if, ntc_sort_cell and ntc_temp_rom.
//
// Samples are accepted only while idle; every fifth accepted beat closes a group
// whose average is inserted into a chain of SLOT_COUNT sorting cells. After
// the SLOT_COUNT-th group the unit stops accepting samples: the last average
// ripples through the cell chain, the middle cells are summed, the
// temperature table is read, and the result beat is loaded into the output
// register. If that register still holds an untaken result, the unit waits.
`default_nettype none

module ntc_trimmed_mean_temperature_unit import ntc_pkg::*; #(
  parameter int SLOT_COUNT = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ntc_in_if.sink    in_bus,
  ntc_out_if.source out_bus
);

  localparam int TRIM_N  = SLOT_COUNT - 2;
  localparam int TRIM_SH = $clog2(TRIM_N);
  localparam int TSUM_W  = SAMPLE_W + $clog2(TRIM_N + 1);
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int DRAIN_N = SLOT_COUNT + 1;
  localparam int DRAIN_W = $clog2(DRAIN_N + 1);
  localparam int GCNT_W  = 3;
  localparam int PROD_W  = 2 * GSUM_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DRAIN = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_ROM   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [GSUM_W-1:0]    gsum_r, gsum_nxt;
  logic [GCNT_W-1:0]    gcnt_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [DRAIN_W-1:0]   drain_r;
  logic [SAMPLE_W-1:0]  filt_r;
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_filt_r;
  logic [TEMP_W-1:0]    out_temp_r;
  sort_pass_t           ins_r;
  logic                 accept;
  logic                 group_done;
  logic                 round_done;
  logic [PROD_W-1:0]    avg_prod;
  logic [TSUM_W-1:0]    trim_sum;
  logic [TEMP_W-1:0]    rom_data;
  logic                 cells_clear;
  logic                 out_free;

  sort_pass_t           chain [SLOT_COUNT+1];
  logic [SAMPLE_W-1:0]  cell_val [SLOT_COUNT];

  assign accept     = in_bus.valid && in_bus.ready;
  assign group_done = gcnt_r >= GCNT_W'(GROUP_LEN - 1);
  assign round_done = group_done && (slot_r == SLOT_W'(SLOT_COUNT - 1));
  assign gsum_nxt   = gsum_r + GSUM_W'(in_bus.adc_sample);
  assign avg_prod   = PROD_W'(gsum_nxt) * PROD_W'(RECIP5_Q15);
  assign out_free   = !out_valid_r || out_bus.ready;

  // Group accumulation and slot counting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsum_r <= '0;
      gcnt_r <= '0;
      slot_r <= '0;
      ins_r  <= '0;
    end else begin
      ins_r.valid <= 1'b0;
      if (accept) begin
        if (group_done) begin
          gsum_r      <= '0;
          gcnt_r      <= '0;
          slot_r      <= round_done ? '0 : slot_r + 1'b1;
          ins_r.valid <= 1'b1;
          ins_r.value <= avg_prod[RECIP5_SH +: SAMPLE_W];
        end else begin
          gsum_r <= gsum_nxt;
          gcnt_r <= gcnt_r + 1'b1;
        end
      end
    end
  end

  // Sorting chain; the last cell's overflow is dropped.
  assign chain[0] = ins_r;
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    ntc_sort_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (cells_clear),
      .pass_in  (chain[g]),
      .pass_out (chain[g+1]),
      .value    (cell_val[g])
    );
  end

  // Sum of the middle cells, dropping smallest and largest.
  always_comb begin
    trim_sum = '0;
    for (int i = 1; i <= TRIM_N; i++) begin
      trim_sum = trim_sum + TSUM_W'(cell_val[i]);
    end
  end

  ntc_temp_rom u_rom (
    .clk  (clk),
    .addr (filt_r),
    .data (rom_data)
  );

  // Sequencer for the conversion at the end of a round.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && round_done) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == DRAIN_W'(DRAIN_N)) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_ROM;
      ST_ROM:   state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign cells_clear = (state_r == ST_SUM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= (state_r == ST_DRAIN) ? drain_r + 1'b1 : '0;
    end
  end

  // Filtered value capture.
  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      filt_r <= SAMPLE_W'(trim_sum >> TRIM_SH);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
      out_filt_r  <= filt_r;
      out_temp_r  <= rom_data;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_bus.ready           = (state_r == ST_IDLE);
  assign out_bus.valid          = out_valid_r;
  assign out_bus.filtered_adc   = out_filt_r;
  assign out_bus.temperature_q4 = out_temp_r;

endmodule

`default_nettype wire

FILE: rtl/core/ntc_sort_cell.sv
// One cell of the systolic insertion sorter: keeps the smaller value,
// hands the larger one to its neighbor. Depends on ntc_pkg.
`default_nettype none

module ntc_sort_cell import ntc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clear,
  input  wire sort_pass_t          pass_in,
  output sort_pass_t               pass_out,
  output logic [SAMPLE_W-1:0]      value
);

  logic [SAMPLE_W-1:0] value_r;
  logic                pvalid_r;
  logic [SAMPLE_W-1:0] pvalue_r;
  logic                take_new;

  assign take_new = pass_in.value < value_r;

  // Keep the minimum; a cleared cell holds the largest code as empty.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      value_r  <= CELL_EMPTY;
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= pass_in.valid;
      if (pass_in.valid) begin
        value_r  <= take_new ? pass_in.value : value_r;
        pvalue_r <= take_new ? value_r : pass_in.value;
      end
    end
  end

  assign pass_out.valid = pvalid_r;
  assign pass_out.value = pvalue_r;
  assign value          = value_r;

endmodule

`default_nettype wire

FILE: rtl/core/ntc_temp_rom.sv
// Temperature lookup table over the filtered value, registered read.
// Depends on ntc_pkg.
`default_nettype none

module ntc_temp_rom import ntc_pkg::*; (
  input  wire logic                clk,
  input  wire logic [SAMPLE_W-1:0] addr,
  output logic [TEMP_W-1:0]        data
);

  localparam temp_rom_t ROM = build_temp_rom();

  logic [TEMP_W-1:0] data_r;

  // Synchronous read.
  always_ff @(posedge clk) begin
    data_r <= ROM[addr];
  end

  assign data = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/ntc_port_checker.sv
// Port-level checks for the NTC trimmed-mean temperature unit.
// Depends on ntc_pkg and the top level; bound to the top level below.
`default_nettype none

module ntc_port_checker import ntc_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] out_filt,
  input wire logic [TEMP_W-1:0]   out_temp
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filt) && $stable(out_temp))
    else $error("result beat changed while stalled");

  // Temperature stays within 0..110 C.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp <= TEMP_W'(MAX_Q4))
    else $error("temperature out of range");

  // A new result only appears after the input side has been held off.
  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while accepting samples");

  // A result beat does not rise while a sample is offered, unless the input was held off.
  a_input_idle_gap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !(in_valid && $past(in_ready)))
    else $error("sample accepted during conversion");

endmodule

bind ntc_trimmed_mean_temperature_unit ntc_port_checker u_ntc_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_filt  (out_bus.filtered_adc),
  .out_temp  (out_bus.temperature_q4)
);

`default_nettype wire

FILE: tb/tb_ntc_trimmed_mean_temperature_unit.sv
// Testbench for the NTC trimmed-mean temperature unit.
// Drives samples, predicts filtered values and temperatures, checks each result beat.
// Depends on ntc_pkg, ntc_if and the unit's RTL.
`default_nettype none

module tb_ntc_trimmed_mean_temperature_unit import ntc_pkg::*; ();

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered_adc;
    logic [TEMP_W-1:0]   temperature_q4;
  } reading_t;

  localparam int NUM_GROUPS   = 10;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  ntc_in_if  in_bus ();
  ntc_out_if out_bus ();

  ntc_trimmed_mean_temperature_unit #(.SLOT_COUNT(NUM_GROUPS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  // Predictor state.
  logic [GSUM_W-1:0]   acc_sum;
  int unsigned         acc_count;
  int unsigned         slot_pos;
  logic [SAMPLE_W-1:0] group_avg [NUM_GROUPS];

  logic [SAMPLE_W-1:0] sample_queue [$];
  reading_t            expected_readings [$];
  int unsigned         error_count;
  int unsigned         readings_seen;
  int unsigned         cycle_count;
  int unsigned         send_gap;
  int unsigned         recv_gap;
  int unsigned         hold_cycles;
  bit                  calm_phase;

  // Log2 in Q32 by normalizing to [1,2) and repeated squaring.
  function automatic longint unsigned q32_log2(input int unsigned n_in);
    int unsigned     n;
    int unsigned     k;
    longint unsigned m;
    longint unsigned frac;
    n    = (n_in == 0) ? 1 : n_in;
    k    = 0;
    frac = 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = longint'(n) << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(k) << 32) | frac;
  endfunction

  // Beta-equation temperature in 1/16 C for a filtered value.
  function automatic logic [TEMP_W-1:0] celsius_q4(input int unsigned v_in);
    int unsigned     v;
    longint unsigned la;
    longint unsigned lb;
    longint unsigned mag;
    longint unsigned p;
    longint unsigned den;
    longint unsigned kelvin;
    longint unsigned q;
    bit              neg;
    v   = (v_in == 0) ? 1 : v_in;
    la  = q32_log2(9 * (1024 - v));
    lb  = q32_log2(25 * v);
    neg = la < lb;
    mag = (neg ? (lb - la) : (la - lb)) >> 8;
    p   = (mag * C_298LN2_Q28) >> 28;
    den = BETA_Q24;
    if (neg) begin
      if (p >= den) return TEMP_W'(MAX_Q4);
      den = den - p;
    end else begin
      den = den + p;
    end
    kelvin = (BETA_T0 << 40) / den;
    if (kelvin < ZERO_C_Q16) return '0;
    q = (kelvin - ZERO_C_Q16 + 64'd2048) >> 12;
    if (q > MAX_Q4) q = MAX_Q4;
    return q[TEMP_W-1:0];
  endfunction

  // Fold one accepted sample into the predictor; queue a reading when due.
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] tmp;
    int unsigned         total;
    reading_t            r;
    acc_sum = acc_sum + GSUM_W'(s);
    acc_count++;
    if (acc_count < GROUP_LEN) return;
    acc_count = 0;
    if (slot_pos >= NUM_GROUPS) slot_pos = 0;
    group_avg[slot_pos] = SAMPLE_W'(acc_sum / GROUP_LEN);
    acc_sum = '0;
    slot_pos++;
    if (slot_pos < NUM_GROUPS) return;
    slot_pos = 0;
    for (int i = 0; i < NUM_GROUPS - 1; i++) begin
      for (int j = i + 1; j < NUM_GROUPS; j++) begin
        if (group_avg[i] > group_avg[j]) begin
          tmp          = group_avg[i];
          group_avg[i] = group_avg[j];
          group_avg[j] = tmp;
        end
      end
    end
    total = 0;
    for (int i = 1; i < NUM_GROUPS - 1; i++) total += group_avg[i];
    r.filtered_adc   = SAMPLE_W'(total >> 3);
    r.temperature_q4 = celsius_q4(r.filtered_adc);
    expected_readings.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Queue one full window of 50 samples spread around a center value.
  task automatic queue_window(input int unsigned center, input int unsigned spread);
    int unsigned lo;
    int unsigned hi;
    lo = (center > spread) ? center - spread : 0;
    hi = (center + spread > 1023) ? 1023 : center + spread;
    for (int i = 0; i < GROUP_LEN * NUM_GROUPS; i++) begin
      sample_queue.push_back(SAMPLE_W'($urandom_range(hi, lo)));
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offers queued samples with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.adc_sample <= '0;
      send_gap          <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) absorb_sample(in_bus.adc_sample);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (sample_queue.size() > 0 && hold_cycles == 0 &&
                     !calm_phase && $urandom_range(9) == 0) begin
          send_gap     <= $urandom_range(7, 1) - 1;
          in_bus.valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_bus.valid      <= 1'b1;
          in_bus.adc_sample <= sample_queue.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random bursts of stall plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap      <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      out_bus.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap      <= recv_gap - 1;
      out_bus.ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(3) == 0) begin
      recv_gap      <= $urandom_range(7, 1) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        $display("result beat with no prediction pending");
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_bus.filtered_adc !== want.filtered_adc)
          report_mismatch("filtered_adc", out_bus.filtered_adc, want.filtered_adc);
        if (out_bus.temperature_q4 !== want.temperature_q4)
          report_mismatch("temperature_q4", out_bus.temperature_q4,
                          want.temperature_q4);
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    acc_sum       = '0;
    acc_count     = 0;
    slot_pos      = 0;
    error_count   = 0;
    readings_seen = 0;
    cycle_count   = 0;
    hold_cycles   = 0;
    calm_phase    = 1'b0;
    for (int i = 0; i < NUM_GROUPS; i++) group_avg[i] = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a window of half zero and half full-scale samples.
    for (int i = 0; i < 25; i++) sample_queue.push_back('0);
    for (int i = 0; i < 25; i++) sample_queue.push_back('1);
    // Then pad with zeros to a second, all-zero window (zero filtered value).
    while (sample_queue.size() < 100) sample_queue.push_back('0);
    // Random windows over the whole range and around both clamp ends.
    for (int w = 0; w < 22; w++) begin
      case (w % 4)
        0: queue_window($urandom_range(1023), 1023);
        1: queue_window($urandom_range(1023), $urandom_range(40));
        2: queue_window($urandom_range(60), 20);
        default: queue_window($urandom_range(1023, 960), 30);
      endcase
      // Long receiver hold-off once while the sender keeps offering.
      if (w == 6) begin
        wait (sample_queue.size() < 200);
        @(posedge clk);
        hold_cycles <= 3000;
      end
    end
    // Last part: no idling on either side.
    wait (sample_queue.size() < 150);
    @(posedge clk);
    calm_phase <= 1'b1;
    wait (sample_queue.size() == 0 && !in_bus.valid);
    wait (expected_readings.size() == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d result beats from zero, full-scale and random windows,",
             readings_seen);
    $display("with random stalls and one long output hold-off");
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/ntc_pkg.sv
rtl/core/ntc_if.sv
rtl/core/ntc_sort_cell.sv
rtl/core/ntc_temp_rom.sv
rtl/core/ntc_trimmed_mean_temperature_unit.sv
rtl/core/ntc_port_checker.sv
tb/tb_ntc_trimmed_mean_temperature_unit.sv
